// ===== rtl/three_field_lattice_verlet_step_unit_macros.svh =====
// Assertion macros shared by the lattice step unit.
`ifndef THREE_FIELD_LATTICE_VERLET_STEP_UNIT_MACROS_SVH
`define THREE_FIELD_LATTICE_VERLET_STEP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TFL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfl: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TFL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfl: next-cycle check failed");

`endif

// ===== rtl/tfl_pkg.sv =====
// Types, constants and saturating helpers for the lattice step unit.
package tfl_pkg;

    localparam int WORD_BITS      = 48;
    localparam int FRACTION_BITS  = 32;
    localparam int KNOB_BITS      = WORD_BITS - 1;
    localparam int DAMP_BITS      = 33;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LANES          = 3;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE_Q    = word_t'(64'd1 << FRACTION_BITS);

    localparam logic signed [WORD_BITS-1:0] MU_RESET    = -48'sd85899345920;
    localparam logic [KNOB_BITS-1:0]        KAPPA_RESET = 47'd85899345920;
    localparam logic [KNOB_BITS-1:0]        MASS_RESET  = 47'd4294967296;
    localparam logic [KNOB_BITS-1:0]        DT_RESET    = 47'd107374182;
    localparam logic [KNOB_BITS-1:0]        ISQ_RESET   = 47'd1717986918400;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_COUPLING_MU       = 3'd0,
        REG_SATURATION_KAPPA  = 3'd1,
        REG_MASS_SQ_FIRST_TWO = 3'd2,
        REG_MASS_SQ_THIRD     = 3'd3,
        REG_TIME_STEP         = 3'd4,
        REG_INV_SPACING_SQ    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        word_t                field_one;
        word_t                field_two;
        word_t                field_three;
        word_t                speed_one;
        word_t                speed_two;
        word_t                speed_three;
        word_t                accel_one;
        word_t                accel_two;
        word_t                accel_three;
        logic [DAMP_BITS-1:0] damping;
        logic                 final_site;
    } site_t;

    typedef struct packed {
        word_t new_field_one;
        word_t new_field_two;
        word_t new_field_three;
        word_t new_speed_one;
        word_t new_speed_two;
        word_t new_speed_three;
        word_t new_accel_one;
        word_t new_accel_two;
        word_t new_accel_three;
        logic  end_of_lattice;
    } result_t;

    // Per-lane operands: one field of the site plus its neighbourhood.
    typedef struct packed {
        word_t phi;
        word_t speed;
        word_t accel;
        word_t left;
        word_t mid_own;
        word_t other_a;
        word_t other_b;
        word_t half_speed;
        word_t mass;
    } lane_in_t;

    // Operands common to every lane.
    typedef struct packed {
        word_t half_dt;
        word_t dt;
        word_t kappa;
        word_t neg_mu;
        word_t inv_sq;
        word_t mid_one;
        word_t mid_two;
        word_t mid_three;
        word_t damp_prev;
        word_t damp_cur;
    } lane_share_t;

    typedef struct packed {
        logic start;
        logic cur_edge;
        logic do_accel;
        logic emit_prev;
        logic last_site;
    } lane_cmd_t;

    typedef struct packed {
        logic  done;
        word_t phi;
        word_t speed;
        word_t prev_phi;
        word_t prev_speed;
        word_t accel;
        word_t cur_phi;
        word_t cur_speed;
    } lane_out_t;

    function automatic word_t sat_add(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return word_t'(s[WORD_BITS-1:0]);
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return word_t'(s[WORD_BITS-1:0]);
    endfunction

endpackage

// ===== rtl/tfl_qmul.sv =====
// Multi-cycle fixed-point multiplier: half-word partial products, rounding, saturation.
module tfl_qmul
    import tfl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t res
);

    localparam int H  = (WORD_BITS + 1) / 2;
    localparam int PW = 4 * H;
    localparam int QW = PW - FRACTION_BITS;
    localparam logic [PW-1:0] RND = PW'(1) << (FRACTION_BITS - 1);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_ACC  = 3'b010,
        M_FIN  = 3'b100
    } mul_state_t;

    mul_state_t         state_reg, state_next;
    logic [1:0]         cnt_reg;
    logic               neg_reg;
    logic [2*H-1:0]     ma_reg, mb_reg;
    logic [PW-1:0]      acc_reg;
    word_t              res_reg;
    logic               done_reg;

    logic [WORD_BITS-1:0] a_mag, b_mag;
    logic [H-1:0]         part_a, part_b;
    logic [2*H-1:0]       pp;
    logic [1:0]           shamt;
    logic [PW-1:0]        pp_sh, rnd;
    logic [QW-1:0]        q, lim;
    word_t                fin;

    always_comb
    begin
        a_mag  = a[WORD_BITS-1] ? (~a + 1'b1) : a;
        b_mag  = b[WORD_BITS-1] ? (~b + 1'b1) : b;
        part_a = cnt_reg[1] ? ma_reg[2*H-1:H] : ma_reg[H-1:0];
        part_b = cnt_reg[0] ? mb_reg[2*H-1:H] : mb_reg[H-1:0];
        pp     = part_a * part_b;
        shamt  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        case (shamt)
            2'd0:    pp_sh = PW'(pp);
            2'd1:    pp_sh = PW'(pp) << H;
            2'd2:    pp_sh = PW'(pp) << (2 * H);
            default: pp_sh = '0;
        endcase
        rnd = acc_reg + RND;
        q   = rnd[PW-1:FRACTION_BITS];
        lim = {{(QW-WORD_BITS){1'b0}}, WORD_MAX} + QW'(neg_reg);
        if (q > lim)
            fin = neg_reg ? WORD_MIN : WORD_MAX;
        else if (neg_reg)
            fin = word_t'(~q[WORD_BITS-1:0] + 1'b1);
        else
            fin = word_t'(q[WORD_BITS-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:  if (start) state_next = M_ACC;
            M_ACC:   if (cnt_reg == 2'd3) state_next = M_FIN;
            M_FIN:   state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_FIN);
            if (state_reg == M_IDLE)
                cnt_reg <= '0;
            else if (state_reg == M_ACC)
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            ma_reg  <= (2*H)'(a_mag);
            mb_reg  <= (2*H)'(b_mag);
            neg_reg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            acc_reg <= '0;
        end
        else if (state_reg == M_ACC)
            acc_reg <= acc_reg + pp_sh;
        if (state_reg == M_FIN)
            res_reg <= fin;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/tfl_qdiv.sv =====
// Restoring fixed-point divider, one quotient bit per cycle, rounding and saturation.
module tfl_qdiv
    import tfl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t res
);

    localparam int N  = WORD_BITS + FRACTION_BITS + 1;
    localparam int CW = $clog2(N + 1);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIN  = 3'b100
    } div_state_t;

    div_state_t           state_reg, state_next;
    logic [CW-1:0]        cnt_reg;
    logic                 neg_reg, zero_reg, done_reg;
    logic [WORD_BITS-1:0] d_reg, r_reg;
    logic [N-1:0]         dq_reg;
    word_t                res_reg;

    logic [WORD_BITS-1:0] a_mag, b_mag;
    logic [N-1:0]         dividend, lim;
    logic [WORD_BITS:0]   rsh, rdiff;
    logic                 ge;
    word_t                fin;

    always_comb
    begin
        a_mag    = a[WORD_BITS-1] ? (~a + 1'b1) : a;
        b_mag    = b[WORD_BITS-1] ? (~b + 1'b1) : b;
        dividend = N'({a_mag, {FRACTION_BITS{1'b0}}}) + N'(b_mag >> 1);
        rsh      = {r_reg, dq_reg[N-1]};
        rdiff    = rsh - {1'b0, d_reg};
        ge       = (rsh >= {1'b0, d_reg});
        lim      = N'(WORD_MAX) + N'(neg_reg);
        if (zero_reg || dq_reg > lim)
            fin = neg_reg ? WORD_MIN : WORD_MAX;
        else if (neg_reg)
            fin = word_t'(~dq_reg[WORD_BITS-1:0] + 1'b1);
        else
            fin = word_t'(dq_reg[WORD_BITS-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (start) state_next = D_RUN;
            D_RUN:   if (cnt_reg == CW'(1)) state_next = D_FIN;
            D_FIN:   state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_FIN);
            if (state_reg == D_IDLE && start)
                cnt_reg <= CW'(N);
            else if (state_reg == D_RUN)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            neg_reg  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            zero_reg <= (b_mag == '0);
            d_reg    <= b_mag;
            r_reg    <= '0;
            dq_reg   <= dividend;
        end
        else if (state_reg == D_RUN)
        begin
            r_reg  <= ge ? rdiff[WORD_BITS-1:0] : rsh[WORD_BITS-1:0];
            dq_reg <= {dq_reg[N-2:0], ge};
        end
        if (state_reg == D_FIN)
            res_reg <= fin;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/tfl_lane.sv =====
// One field lane: kick, drift, new acceleration, second kick and damping, micro-sequenced.
module tfl_lane
    import tfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lane_cmd_t   cmd,
    input  lane_in_t    din,
    input  lane_share_t share,
    output lane_out_t   dout
);

    typedef enum logic [4:0] {
        OP_KICK, OP_DRIFT, OP_T01, OP_P, OP_PP, OP_KPP, OP_DEN, OP_DP, OP_MUP,
        OP_NUM, OP_LAP, OP_MASS, OP_VEL, OP_EPF, OP_EPV, OP_ECF, OP_ECV
    } op_t;

    typedef enum logic [4:0] {
        L_IDLE  = 5'b00001,
        L_ISSUE = 5'b00010,
        L_MUL   = 5'b00100,
        L_DIV   = 5'b01000,
        L_DONE  = 5'b10000
    } lane_state_t;

    lane_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic        edge_reg, accel_reg, prev_reg, last_reg;

    word_t cp_reg, cv_reg, t_reg, pv_reg, den_reg, num_reg, force_reg, lap_reg;
    word_t acc_reg, vel_reg, epf_reg, epv_reg, ecf_reg, ecv_reg;

    logic  op_en, mul_start, mul_done, div_start, div_done;
    word_t mul_a, mul_b, mul_res, div_res, lap_raw;

    always_comb
    begin
        case (op_reg)
            OP_KICK, OP_DRIFT:                    op_en = !edge_reg;
            OP_T01, OP_P, OP_PP, OP_KPP, OP_DEN,
            OP_DP, OP_MUP, OP_NUM, OP_LAP,
            OP_MASS, OP_VEL:                      op_en = accel_reg;
            OP_EPF, OP_EPV:                       op_en = prev_reg;
            OP_ECF, OP_ECV:                       op_en = last_reg;
            default:                              op_en = 1'b0;
        endcase
    end

    // Second difference of the neighbours, saturating at each step.
    assign lap_raw = sat_sub(sat_sub(sat_add(din.left, cp_reg), din.mid_own), din.mid_own);

    always_comb
    begin
        case (op_reg)
            OP_KICK:  begin mul_a = share.half_dt; mul_b = din.accel;       end
            OP_DRIFT: begin mul_a = share.dt;      mul_b = cv_reg;          end
            OP_T01:   begin mul_a = share.mid_one; mul_b = share.mid_two;   end
            OP_P:     begin mul_a = t_reg;         mul_b = share.mid_three; end
            OP_PP:    begin mul_a = pv_reg;        mul_b = pv_reg;          end
            OP_KPP:   begin mul_a = share.kappa;   mul_b = t_reg;           end
            OP_DEN:   begin mul_a = t_reg;         mul_b = t_reg;           end
            OP_DP:    begin mul_a = din.other_a;   mul_b = din.other_b;     end
            OP_MUP:   begin mul_a = share.neg_mu;  mul_b = pv_reg;          end
            OP_NUM:   begin mul_a = num_reg;       mul_b = t_reg;           end
            OP_LAP:   begin mul_a = lap_raw;       mul_b = share.inv_sq;    end
            OP_MASS:  begin mul_a = din.mass;      mul_b = din.mid_own;     end
            OP_VEL:   begin mul_a = share.half_dt; mul_b = acc_reg;         end
            OP_EPF:   begin mul_a = din.mid_own;   mul_b = share.damp_prev; end
            OP_EPV:   begin mul_a = vel_reg;       mul_b = share.damp_prev; end
            OP_ECF:   begin mul_a = cp_reg;        mul_b = share.damp_cur;  end
            OP_ECV:   begin mul_a = cv_reg;        mul_b = share.damp_cur;  end
            default:  begin mul_a = '0;            mul_b = '0;              end
        endcase
    end

    assign mul_start = (state_reg == L_ISSUE) && op_en;
    assign div_start = (state_reg == L_MUL) && mul_done && (op_reg == OP_NUM);

    tfl_qmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    tfl_qdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (mul_res),
        .b     (den_reg),
        .done  (div_done),
        .res   (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (cmd.start)
                begin
                    state_next = L_ISSUE;
                    op_next    = OP_KICK;
                end
            end
            L_ISSUE:
            begin
                if (op_en)
                    state_next = L_MUL;
                else if (op_reg == OP_ECV)
                    state_next = L_DONE;
                else
                    op_next = op_t'(op_reg + 5'd1);
            end
            L_MUL:
            begin
                if (mul_done)
                begin
                    if (op_reg == OP_NUM)
                        state_next = L_DIV;
                    else if (op_reg == OP_ECV)
                        state_next = L_DONE;
                    else
                    begin
                        state_next = L_ISSUE;
                        op_next    = op_t'(op_reg + 5'd1);
                    end
                end
            end
            L_DIV:
            begin
                if (div_done)
                begin
                    state_next = L_ISSUE;
                    op_next    = op_t'(op_reg + 5'd1);
                end
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            op_reg    <= OP_KICK;
            edge_reg  <= 1'b0;
            accel_reg <= 1'b0;
            prev_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if ((state_reg == L_IDLE || state_reg == L_DONE) && cmd.start)
            begin
                edge_reg  <= cmd.cur_edge;
                accel_reg <= cmd.do_accel;
                prev_reg  <= cmd.emit_prev;
                last_reg  <= cmd.last_site;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == L_IDLE || state_reg == L_DONE) && cmd.start)
        begin
            cp_reg  <= din.phi;
            cv_reg  <= din.speed;
            acc_reg <= '0;
            vel_reg <= din.half_speed;
        end
        else if (state_reg == L_MUL && mul_done)
        begin
            case (op_reg)
                OP_KICK:              cv_reg  <= sat_add(din.speed, mul_res);
                OP_DRIFT:             cp_reg  <= sat_add(din.phi, mul_res);
                OP_T01, OP_PP, OP_DP: t_reg   <= mul_res;
                OP_P:                 pv_reg  <= mul_res;
                OP_KPP:               t_reg   <= sat_add(ONE_Q, mul_res);
                OP_DEN:               den_reg <= mul_res;
                OP_MUP:               num_reg <= mul_res;
                OP_LAP:               lap_reg <= mul_res;
                OP_MASS:  acc_reg <= sat_add(sat_sub(lap_reg, mul_res), force_reg);
                OP_VEL:   vel_reg <= sat_add(din.half_speed, mul_res);
                OP_EPF:               epf_reg <= mul_res;
                OP_EPV:               epv_reg <= mul_res;
                OP_ECF:               ecf_reg <= mul_res;
                OP_ECV:               ecv_reg <= mul_res;
                default: ;
            endcase
        end
        if (state_reg == L_DIV && div_done)
            force_reg <= div_res;
    end

    assign dout.done       = (state_reg == L_DONE);
    assign dout.phi        = cp_reg;
    assign dout.speed      = cv_reg;
    assign dout.prev_phi   = epf_reg;
    assign dout.prev_speed = epv_reg;
    assign dout.accel      = acc_reg;
    assign dout.cur_phi    = ecf_reg;
    assign dout.cur_speed  = ecv_reg;

endmodule

// ===== rtl/three_field_lattice_verlet_step_unit.sv =====
// Each lane runs up to 15 multiplies in turn, plus one divide when it computes a new acceleration.
// Sites are taken one at a time, each after the last one's hand-over; result stalls delay it,
//   as the hand-over waits for an empty queue. Results leave when the right neighbour arrives.
// Reset: rst_n clears the sequencer, queue and history and loads the register defaults.
`include "three_field_lattice_verlet_step_unit_macros.svh"

module three_field_lattice_verlet_step_unit
    import tfl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data,
    input  logic                      site_valid,
    output logic                      site_stall,
    input  site_t                     site,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result
);

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_START = 3'b010,
        T_RUN   = 3'b100
    } top_state_t;

    typedef enum logic [1:0] {
        SS_NONE = 2'd0,
        SS_ONE  = 2'd1,
        SS_MANY = 2'd2
    } seen_t;

    // Configuration registers
    word_t                mu_reg;
    logic [KNOB_BITS-1:0] kappa_reg, mass12_reg, mass3_reg, dt_reg, isq_reg;

    // Lattice history: two drifted sites back and the pending site's half-kicked speed
    top_state_t           state_reg, state_next;
    seen_t                ss_reg;
    word_t                older_reg [LANES];
    word_t                newer_reg [LANES];
    word_t                hs_reg    [LANES];
    logic [DAMP_BITS-1:0] dampn_reg;
    site_t                item_reg;

    // Output queue, head in slot0
    result_t              slot0_reg, slot1_reg;
    logic [1:0]           count_reg;

    logic        accept, pop, merge, all_done;
    lane_cmd_t   cmd;
    lane_share_t share;
    lane_in_t    lane_in  [LANES];
    lane_out_t   lane_out [LANES];
    word_t       item_phi [LANES];
    word_t       item_spd [LANES];
    word_t       item_acc [LANES];
    result_t     prev_res, cur_res;

    assign site_stall   = (state_reg != T_IDLE);
    assign accept       = site_valid && !site_stall;
    assign result_valid = (count_reg != 2'd0);
    assign result       = slot0_reg;
    assign pop          = result_valid && !result_stall;
    assign all_done     = lane_out[0].done && lane_out[1].done && lane_out[2].done;
    // Hand over only into an empty queue so both results of a last site always fit
    assign merge        = (state_reg == T_RUN) && all_done && (count_reg == 2'd0);

    assign item_phi[0] = item_reg.field_one;
    assign item_phi[1] = item_reg.field_two;
    assign item_phi[2] = item_reg.field_three;
    assign item_spd[0] = item_reg.speed_one;
    assign item_spd[1] = item_reg.speed_two;
    assign item_spd[2] = item_reg.speed_three;
    assign item_acc[0] = item_reg.accel_one;
    assign item_acc[1] = item_reg.accel_two;
    assign item_acc[2] = item_reg.accel_three;

    always_comb
    begin
        cmd.start     = (state_reg == T_START);
        cmd.cur_edge  = (ss_reg == SS_NONE) || item_reg.final_site;
        cmd.do_accel  = (ss_reg == SS_MANY);
        cmd.emit_prev = (ss_reg != SS_NONE);
        cmd.last_site = item_reg.final_site;

        share.dt        = word_t'({1'b0, dt_reg});
        share.half_dt   = word_t'(({1'b0, dt_reg} + WORD_BITS'(1)) >> 1);
        share.kappa     = word_t'({1'b0, kappa_reg});
        share.neg_mu    = sat_sub('0, mu_reg);
        share.inv_sq    = word_t'({1'b0, isq_reg});
        share.mid_one   = newer_reg[0];
        share.mid_two   = newer_reg[1];
        share.mid_three = newer_reg[2];
        share.damp_prev = word_t'({{(WORD_BITS-DAMP_BITS){1'b0}}, dampn_reg});
        share.damp_cur  = word_t'({{(WORD_BITS-DAMP_BITS){1'b0}}, item_reg.damping});
    end

    // One lane per field; the product terms of the coupling force use the other two fields
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        localparam int OA = (g == 0) ? 1 : 0;
        localparam int OB = (g == 2) ? 1 : 2;

        always_comb
        begin
            lane_in[g].phi        = item_phi[g];
            lane_in[g].speed      = item_spd[g];
            lane_in[g].accel      = item_acc[g];
            lane_in[g].left       = older_reg[g];
            lane_in[g].mid_own    = newer_reg[g];
            lane_in[g].other_a    = newer_reg[OA];
            lane_in[g].other_b    = newer_reg[OB];
            lane_in[g].half_speed = hs_reg[g];
            lane_in[g].mass       = (g == 2) ? word_t'({1'b0, mass3_reg})
                                             : word_t'({1'b0, mass12_reg});
        end

        tfl_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .din   (lane_in[g]),
            .share (share),
            .dout  (lane_out[g])
        );
    end

    // Merge: gather the three lanes into the pending site's and the current site's results
    always_comb
    begin
        prev_res.new_field_one   = lane_out[0].prev_phi;
        prev_res.new_field_two   = lane_out[1].prev_phi;
        prev_res.new_field_three = lane_out[2].prev_phi;
        prev_res.new_speed_one   = lane_out[0].prev_speed;
        prev_res.new_speed_two   = lane_out[1].prev_speed;
        prev_res.new_speed_three = lane_out[2].prev_speed;
        prev_res.new_accel_one   = lane_out[0].accel;
        prev_res.new_accel_two   = lane_out[1].accel;
        prev_res.new_accel_three = lane_out[2].accel;
        prev_res.end_of_lattice  = 1'b0;

        cur_res.new_field_one    = lane_out[0].cur_phi;
        cur_res.new_field_two    = lane_out[1].cur_phi;
        cur_res.new_field_three  = lane_out[2].cur_phi;
        cur_res.new_speed_one    = lane_out[0].cur_speed;
        cur_res.new_speed_two    = lane_out[1].cur_speed;
        cur_res.new_speed_three  = lane_out[2].cur_speed;
        cur_res.new_accel_one    = '0;
        cur_res.new_accel_two    = '0;
        cur_res.new_accel_three  = '0;
        cur_res.end_of_lattice   = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:  if (accept) state_next = T_START;
            T_START: state_next = T_RUN;
            T_RUN:   if (merge) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // Control, configuration and lattice history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            ss_reg     <= SS_NONE;
            count_reg  <= 2'd0;
            dampn_reg  <= '0;
            mu_reg     <= MU_RESET;
            kappa_reg  <= KAPPA_RESET;
            mass12_reg <= MASS_RESET;
            mass3_reg  <= MASS_RESET;
            dt_reg     <= DT_RESET;
            isq_reg    <= ISQ_RESET;
            for (int i = 0; i < LANES; i++)
            begin
                older_reg[i] <= '0;
                newer_reg[i] <= '0;
                hs_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_COUPLING_MU:       mu_reg     <= word_t'(cfg_data);
                    REG_SATURATION_KAPPA:  kappa_reg  <= cfg_data[KNOB_BITS-1:0];
                    REG_MASS_SQ_FIRST_TWO: mass12_reg <= cfg_data[KNOB_BITS-1:0];
                    REG_MASS_SQ_THIRD:     mass3_reg  <= cfg_data[KNOB_BITS-1:0];
                    REG_TIME_STEP:         dt_reg     <= cfg_data[KNOB_BITS-1:0];
                    REG_INV_SPACING_SQ:    isq_reg    <= cfg_data[KNOB_BITS-1:0];
                    default: ;
                endcase
            end

            if (merge)
            begin
                count_reg <= {1'b0, cmd.emit_prev} + {1'b0, item_reg.final_site};
                if (item_reg.final_site)
                begin
                    // Drop the whole history: the next site opens a new lattice
                    ss_reg    <= SS_NONE;
                    dampn_reg <= '0;
                    for (int i = 0; i < LANES; i++)
                    begin
                        older_reg[i] <= '0;
                        newer_reg[i] <= '0;
                        hs_reg[i]    <= '0;
                    end
                end
                else
                begin
                    // Advance the window by one site
                    dampn_reg <= item_reg.damping;
                    if (ss_reg != SS_MANY)
                        ss_reg <= seen_t'(ss_reg + 2'd1);
                    for (int i = 0; i < LANES; i++)
                    begin
                        older_reg[i] <= newer_reg[i];
                        newer_reg[i] <= lane_out[i].phi;
                        hs_reg[i]    <= lane_out[i].speed;
                    end
                end
            end
            else if (pop)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Payload: captured site and queue slots
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= site;
        if (merge)
        begin
            if (cmd.emit_prev)
            begin
                slot0_reg <= prev_res;
                slot1_reg <= cur_res;
            end
            else
                slot0_reg <= cur_res;
        end
        else if (pop)
            slot0_reg <= slot1_reg;
    end

    `TFL_ASSERT_IMP(a_lanes_lockstep, lane_out[0].done, lane_out[1].done && lane_out[2].done)
    `TFL_ASSERT_NEXT(a_one_site_in_flight, site_valid && !site_stall, site_stall)
    `TFL_ASSERT_NEXT(a_last_site_clears, merge && item_reg.final_site, ss_reg == SS_NONE)

endmodule

// ===== tb/three_field_lattice_verlet_step_unit_tb.sv =====
// Self-checking testbench for the three-field lattice velocity-Verlet step unit.
module three_field_lattice_verlet_step_unit_tb;
    import tfl_pkg::*;

    // Indexes beyond the register list; writes to these must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_SIX   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_SEVEN = 3'd7;

    localparam longint     W_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint     W_MIN      = -64'sh0000_8000_0000_0000;
    localparam longint     Q_ONE      = 64'sh1_0000_0000;
    localparam logic [46:0] KNOB_TOP  = {47{1'b1}};
    localparam int         STALL_PCT  = 16;
    localparam int         DRAIN_WAIT = 400;
    localparam int         IDLE_LIMIT = 6000;
    localparam int         RAND_ITEMS = 850;

    typedef longint trio_t [3];

    logic    clk;
    logic    rst_n;
    logic    cfg_write;
    logic    [CFG_INDEX_BITS-1:0] cfg_index;
    logic    [WORD_BITS-1:0] cfg_data;
    logic    site_valid;
    logic    site_stall;
    site_t   site;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    three_field_lattice_verlet_step_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .site_valid   (site_valid),
        .site_stall   (site_stall),
        .site         (site),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Predictor copy of the registers and of the lattice history.
    longint mu_q, kappa_q, mass12_q, mass3_q, dt_q, isq_q;
    trio_t  drift_older, drift_newer, half_speed;
    longint damp_newer;
    int     held_sites;

    result_t pending_results[$];
    int      fail_count;
    int      sites_sent;
    int      results_seen;
    int      lattices_sent;
    int      idle_cycles;
    bit      quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- fixed-point arithmetic ----------------

    function automatic longint clampw(longint x);
        if (x > W_MAX) return W_MAX;
        if (x < W_MIN) return W_MIN;
        return x;
    endfunction

    function automatic logic [127:0] magnitude(longint x);
        return (x < 0) ? 128'(-x) : 128'(x);
    endfunction

    // Saturate a sign and magnitude back to a word.
    function automatic longint pack_signed(bit neg, logic [127:0] m);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (m > lim) return neg ? W_MIN : W_MAX;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        p = magnitude(a) * magnitude(b) + (128'd1 << (FRACTION_BITS - 1));
        return pack_signed((a < 0) != (b < 0), p >> FRACTION_BITS);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        logic [127:0] d, n;
        bit neg;
        neg = (a < 0) != (b < 0);
        d = magnitude(b);
        if (d == 0) return neg ? W_MIN : W_MAX;
        n = (magnitude(a) << FRACTION_BITS) + (d >> 1);
        return pack_signed(neg, n / d);
    endfunction

    function automatic longint s_add(longint a, longint b);
        return clampw(a + b);
    endfunction

    function automatic longint s_sub(longint a, longint b);
        return clampw(a - b);
    endfunction

    // Acceleration of field f at the middle of three drifted sites.
    function automatic longint site_accel(int f, trio_t l, trio_t m, trio_t r);
        longint p, den, dp, force_q, lap, mass;
        p   = fx_mul(fx_mul(m[0], m[1]), m[2]);
        den = s_add(Q_ONE, fx_mul(kappa_q, fx_mul(p, p)));
        den = fx_mul(den, den);
        dp  = (f == 0) ? fx_mul(m[1], m[2]) :
              (f == 1) ? fx_mul(m[0], m[2]) : fx_mul(m[0], m[1]);
        force_q = fx_div(fx_mul(fx_mul(s_sub(0, mu_q), p), dp), den);
        lap  = s_sub(s_sub(s_add(l[f], r[f]), m[f]), m[f]);
        lap  = fx_mul(lap, isq_q);
        mass = (f == 2) ? mass3_q : mass12_q;
        return s_add(s_sub(lap, fx_mul(mass, m[f])), force_q);
    endfunction

    function automatic result_t damped_result(trio_t phi, trio_t vel, trio_t acc,
                                              longint damp, bit last);
        result_t r;
        r.new_field_one   = word_t'(fx_mul(phi[0], damp));
        r.new_field_two   = word_t'(fx_mul(phi[1], damp));
        r.new_field_three = word_t'(fx_mul(phi[2], damp));
        r.new_speed_one   = word_t'(fx_mul(vel[0], damp));
        r.new_speed_two   = word_t'(fx_mul(vel[1], damp));
        r.new_speed_three = word_t'(fx_mul(vel[2], damp));
        r.new_accel_one   = word_t'(acc[0]);
        r.new_accel_two   = word_t'(acc[1]);
        r.new_accel_three = word_t'(acc[2]);
        r.end_of_lattice  = last;
        return r;
    endfunction

    // Advance the lattice history by one site and return the results it releases.
    task automatic step_lattice(input site_t s, output result_t outs[$]);
        trio_t  p, v, a, acc, vel, zero3;
        longint dt, half_dt, damp;
        bit     edge_site;
        outs    = {};
        zero3   = '{0, 0, 0};
        dt      = dt_q;
        half_dt = (dt + 1) >>> 1;
        damp    = longint'({31'b0, s.damping});
        edge_site = (held_sites == 0) || s.final_site;
        p = '{longint'(s.field_one), longint'(s.field_two), longint'(s.field_three)};
        v = '{longint'(s.speed_one), longint'(s.speed_two), longint'(s.speed_three)};
        a = '{longint'(s.accel_one), longint'(s.accel_two), longint'(s.accel_three)};
        for (int f = 0; f < 3; f++)
        begin
            if (!edge_site)
            begin
                v[f] = s_add(v[f], fx_mul(half_dt, a[f]));
                p[f] = s_add(p[f], fx_mul(dt, v[f]));
            end
        end
        if (held_sites == 1)
            outs.push_back(damped_result(drift_newer, half_speed, zero3, damp_newer, 1'b0));
        else if (held_sites >= 2)
        begin
            for (int f = 0; f < 3; f++)
            begin
                acc[f] = site_accel(f, drift_older, drift_newer, p);
                vel[f] = s_add(half_speed[f], fx_mul(half_dt, acc[f]));
            end
            outs.push_back(damped_result(drift_newer, vel, acc, damp_newer, 1'b0));
        end
        if (s.final_site)
        begin
            outs.push_back(damped_result(p, v, zero3, damp, 1'b1));
            drift_older = zero3;
            drift_newer = zero3;
            half_speed  = zero3;
            damp_newer  = 0;
            held_sites  = 0;
        end
        else
        begin
            drift_older = drift_newer;
            drift_newer = p;
            half_speed  = v;
            damp_newer  = damp;
            if (held_sites < 2) held_sites++;
        end
    endtask

    // ---------------- driving ----------------

    // Write one register at a falling edge; the block takes it at the next rising edge.
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx, logic [WORD_BITS-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_COUPLING_MU:       mu_q     = longint'($signed(data));
            REG_SATURATION_KAPPA:  kappa_q  = longint'({17'b0, data[46:0]});
            REG_MASS_SQ_FIRST_TWO: mass12_q = longint'({17'b0, data[46:0]});
            REG_MASS_SQ_THIRD:     mass3_q  = longint'({17'b0, data[46:0]});
            REG_TIME_STEP:         dt_q     = longint'({17'b0, data[46:0]});
            REG_INV_SPACING_SQ:    isq_q    = longint'({17'b0, data[46:0]});
            default: ;
        endcase
    endtask

    task automatic write_all(logic [WORD_BITS-1:0] mu, logic [46:0] kappa, logic [46:0] m12,
                             logic [46:0] m3, logic [46:0] dt, logic [46:0] isq);
        write_register(REG_COUPLING_MU, mu);
        write_register(REG_SATURATION_KAPPA, {1'b0, kappa});
        write_register(REG_MASS_SQ_FIRST_TWO, {1'b0, m12});
        write_register(REG_MASS_SQ_THIRD, {1'b0, m3});
        write_register(REG_TIME_STEP, {1'b0, dt});
        write_register(REG_INV_SPACING_SQ, {1'b0, isq});
        // Unknown indexes carry junk that must not land anywhere.
        write_register(REG_SPARE_SIX, WORD_BITS'({$urandom, $urandom}));
        write_register(REG_SPARE_SEVEN, WORD_BITS'({$urandom, $urandom}));
    endtask

    // Hold the sender until every result is back, then let the last edge site settle.
    task automatic drain_results();
        site_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
    endtask

    // Present one site; on acceptance record its expected results.
    task automatic present_site(site_t s, bit typed, result_t typed_result);
        result_t outs[$];
        site       = s;
        site_valid = 1'b1;
        do
            @(posedge clk);
        while (site_stall);
        step_lattice(s, outs);
        if (typed)
            outs = {typed_result};
        foreach (outs[k]) pending_results.push_back(outs[k]);
        sites_sent++;
        if (s.final_site) lattices_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(99) < STALL_PCT)
        begin
            site_valid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
    endtask

    function automatic word_t rand_word();
        return word_t'({$urandom, $urandom});
    endfunction

    function automatic word_t rand_mild(int bits);
        return word_t'($signed({$urandom, $urandom}) >>> (64 - bits));
    endfunction

    // Mostly physical sites; a quarter are full-range noise.
    function automatic site_t rand_site(bit last);
        site_t s;
        if ($urandom_range(3) == 0)
        begin
            s = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word(), rand_word(), rand_word(),
                 33'({$urandom, $urandom}), 1'b0};
        end
        else
        begin
            s.field_one   = rand_mild(35);
            s.field_two   = rand_mild(35);
            s.field_three = rand_mild(35);
            s.speed_one   = rand_mild(34);
            s.speed_two   = rand_mild(34);
            s.speed_three = rand_mild(34);
            s.accel_one   = rand_mild(37);
            s.accel_two   = rand_mild(37);
            s.accel_three = rand_mild(37);
            s.damping     = ($urandom_range(1) == 0) ? 33'(Q_ONE)
                                                      : 33'($urandom_range(32'hFFFF_FFFF));
        end
        s.final_site = last;
        return s;
    endfunction

    function automatic site_t uniform_site(longint fv, longint sv, longint av,
                                           longint damp, bit last);
        return {word_t'(fv), word_t'(-fv), word_t'(fv >>> 1), word_t'(sv), word_t'(-sv),
                word_t'(sv >>> 2), word_t'(av), word_t'(-av), word_t'(av >>> 3),
                33'(damp), last};
    endfunction

    // Single edge site, passed through with damping one and zero acceleration.
    function automatic result_t passthrough(site_t s);
        return {s.field_one, s.field_two, s.field_three, s.speed_one, s.speed_two,
                s.speed_three, word_t'(0), word_t'(0), word_t'(0), 1'b1};
    endfunction

    // ---------------- directed table ----------------

    site_t   dir_site[$];
    bit      dir_typed[$];
    result_t dir_result[$];

    task automatic add_row(site_t s, bit typed, result_t r);
        dir_site.push_back(s);
        dir_typed.push_back(typed);
        dir_result.push_back(r);
    endtask

    task automatic build_table();
        site_t s;
        // Single-site lattices: ordinary, extremes, zero damping, damping past one.
        s = uniform_site(64'sh3_0000_0000, 64'sh1_8000_0000, 64'sh7_0000_0000, Q_ONE, 1);
        add_row(s, 1, passthrough(s));
        s = uniform_site(W_MAX, W_MIN, W_MAX, Q_ONE, 1);
        add_row(s, 1, passthrough(s));
        s = uniform_site(W_MIN, W_MAX, W_MIN, Q_ONE, 1);
        add_row(s, 1, passthrough(s));
        s = uniform_site(W_MAX, W_MIN, W_MAX, 0, 1);
        add_row(s, 1, '{default: '0, end_of_lattice: 1'b1});
        s = uniform_site(W_MAX, W_MIN, 64'sh1_0000, 64'h1_FFFF_FFFF, 1);
        add_row(s, 0, '0);
        // Two-site lattice.
        add_row(uniform_site(64'sh1_0000_0000, 64'sh4000_0000, 64'sh2_0000_0000, Q_ONE, 0), 0, '0);
        add_row(uniform_site(-64'sh2_0000_0000, 64'sh0, -64'sh1_0000_0000, Q_ONE >> 1, 1), 0, '0);
        // Five-site lattice with moderate values.
        for (int k = 0; k < 5; k++)
            add_row(uniform_site(64'sh8000_0000 * (k + 1), -64'sh4000_0000 * k,
                                 64'sh3_0000_0000 - 64'sh1_0000_0000 * k,
                                 Q_ONE - 64'sh1000_0000 * k, k == 4), 0, '0);
        // Four-site lattice at the word limits: every stage saturates.
        for (int k = 0; k < 4; k++)
            add_row(uniform_site(k[0] ? W_MIN : W_MAX, k[1] ? W_MAX : W_MIN,
                                 k[0] ? W_MAX : W_MIN, 64'h1_FFFF_FFFF, k == 3), 0, '0);
        // Six-site lattice near the coupling's sweet spot.
        for (int k = 0; k < 6; k++)
            add_row(uniform_site(64'sh1_4000_0000 + 64'sh1000_0000 * k, 64'sh2000_0000,
                                 -64'sh8000_0000, Q_ONE, k == 5), 0, '0);
    endtask

    // ---------------- checking ----------------

    function automatic void check_field(string name, logic [WORD_BITS-1:0] e,
                                        logic [WORD_BITS-1:0] a);
        if (e !== a)
        begin
            $error("%s: expected %h, got %h", name, e, a);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            result_t e;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("new_field_one",   e.new_field_one,   result.new_field_one);
                check_field("new_field_two",   e.new_field_two,   result.new_field_two);
                check_field("new_field_three", e.new_field_three, result.new_field_three);
                check_field("new_speed_one",   e.new_speed_one,   result.new_speed_one);
                check_field("new_speed_two",   e.new_speed_two,   result.new_speed_two);
                check_field("new_speed_three", e.new_speed_three, result.new_speed_three);
                check_field("new_accel_one",   e.new_accel_one,   result.new_accel_one);
                check_field("new_accel_two",   e.new_accel_two,   result.new_accel_two);
                check_field("new_accel_three", e.new_accel_three, result.new_accel_three);
                check_field("end_of_lattice",  48'(e.end_of_lattice), 48'(result.end_of_lattice));
            end
        end
    end

    // Stall the result side at random, except through the quiet stretch.
    always @(negedge clk)
        result_stall <= !quiet && ($urandom_range(99) < STALL_PCT);

    // Watchdog: any transaction on either side restarts the count.
    always @(posedge clk)
    begin
        if ((site_valid && !site_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial
    begin
        int remaining;
        int lattice_len;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        site_valid   = 1'b0;
        site         = '0;
        quiet        = 1'b0;
        sites_sent   = 0;
        lattices_sent = 0;
        mu_q     = longint'(MU_RESET);
        kappa_q  = longint'({17'b0, KAPPA_RESET});
        mass12_q = longint'({17'b0, MASS_RESET});
        mass3_q  = longint'({17'b0, MASS_RESET});
        dt_q     = longint'({17'b0, DT_RESET});
        isq_q    = longint'({17'b0, ISQ_RESET});
        drift_older = '{0, 0, 0};
        drift_newer = '{0, 0, 0};
        half_speed  = '{0, 0, 0};
        damp_newer  = 0;
        held_sites  = 0;
        build_table();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows under the reset register values.
        foreach (dir_site[k])
            present_site(dir_site[k], dir_typed[k], dir_result[k]);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 6; phase++)
        begin
            drain_results();
            case (phase)
                0: ;
                1: write_all(48'($signed(rand_mild(38))), 47'($urandom_range(32'hFFFF_FFFF)) << 4,
                             47'($urandom) << 2, 47'($urandom) << 2,
                             47'($urandom_range(32'h1FFF_FFFF)),
                             47'($urandom) << 8);
                2: write_all(48'h7FFF_FFFF_FFFF, KNOB_TOP, KNOB_TOP, KNOB_TOP, KNOB_TOP, KNOB_TOP);
                3: write_all(48'h8000_0000_0000, '0, '0, '0, '0, '0);
                4: write_all(48'(MU_RESET), KAPPA_RESET, MASS_RESET, MASS_RESET,
                             DT_RESET, ISQ_RESET);
                default: write_all(48'({$urandom, $urandom}), 47'({$urandom, $urandom}),
                                   47'({$urandom, $urandom}), 47'({$urandom, $urandom}),
                                   47'({$urandom, $urandom}), 47'({$urandom, $urandom}));
            endcase
            // Phase one runs without any idling on either side.
            quiet = (phase == 1);
            remaining = RAND_ITEMS / 6;
            while (remaining > 0)
            begin
                lattice_len = ($urandom_range(9) == 0) ? $urandom_range(30, 12)
                                                       : $urandom_range(8, 1);
                if (lattice_len > remaining) lattice_len = remaining;
                for (int k = 0; k < lattice_len; k++)
                    present_site(rand_site(k == lattice_len - 1), 0, '0);
                remaining -= lattice_len;
            end
        end

        quiet = 1'b0;
        site_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d sites in %0d lattices, %0d results checked", sites_sent,
                 lattices_sent, results_seen);
        $display("register settings: reset, random, all maximum, all minimum, random wide");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tfl_pkg.sv
rtl/tfl_qmul.sv
rtl/tfl_qdiv.sv
rtl/tfl_lane.sv
rtl/three_field_lattice_verlet_step_unit.sv
tb/three_field_lattice_verlet_step_unit_tb.sv
